// ===== sv/cmg_pkg.sv =====
// Shared types and constants for the concave-over-modular gain engine.
// No dependencies; imported by every module of the block except cmg_ram.
package cmg_pkg;

	localparam int MAX_QUERIES = 64;
	localparam int MAX_ITEMS   = 4096;
	localparam int QW          = $clog2(MAX_QUERIES);
	localparam int IW          = $clog2(MAX_ITEMS);
	localparam int NW          = QW + 1;
	localparam int SUM_W       = 32;
	localparam int V_W         = SUM_W + 1;
	localparam int T_W         = 26;
	localparam int GAIN_W      = 40;
	localparam int TOT_W       = 40;
	localparam int WQ_DEPTH    = 2;
	localparam int WQ_PW       = $clog2(WQ_DEPTH);
	localparam logic [31:0] LN2_Q32 = 32'd2977044472;

	typedef enum logic [1:0] {
		OP_GAIN  = 2'd0,
		OP_ADD   = 2'd1,
		OP_CLEAR = 2'd2,
		OP_EVAL  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CFG_KIND   = 2'd0,
		CFG_ETA    = 2'd1,
		CFG_QCOUNT = 2'd2,
		CFG_CHECK  = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [11:0] item_index;
		logic [15:0] kernel_value;
		logic        last_element;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic               already_selected;
	} out_item_t;

	typedef struct packed {
		logic [1:0]  transform_kind;
		logic [15:0] diversity_weight;
		logic [6:0]  query_count;
		logic        check_membership;
	} cfg_t;

	// one row element or command after classification
	typedef struct packed {
		op_t           op;
		logic [IW-1:0] item;
		logic [15:0]   k;
		logic          last;
		logic [QW-1:0] pos;
		logic          act;
	} work_t;

endpackage

// ===== sv/cmg_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cmg_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== sv/cmg_xform.sv =====
// Iterative concave transform: restoring divide, bit-serial root, or log by squaring.
// Depends on cmg_pkg.
module cmg_xform (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [1:0]             kind,
	input  logic [cmg_pkg::V_W-1:0] v,
	output logic                   done,
	output logic [cmg_pkg::T_W-1:0] result
);
	import cmg_pkg::*;

	typedef enum logic [6:0] {
		X_IDLE  = 7'b0000001,
		X_DIV   = 7'b0000010,
		X_SQRT  = 7'b0000100,
		X_LNORM = 7'b0001000,
		X_LSQ   = 7'b0010000,
		X_LFIN  = 7'b0100000,
		X_DONE  = 7'b1000000
	} xstate_t;

	xstate_t     state_q;
	logic [4:0]  cnt_q;
	logic [33:0] r_q, d_q, m_q;
	logic [15:0] q_q, frac_q;
	logic [50:0] n_q, rt_q, bit_q;
	logic [5:0]  e_q;
	logic [30:0] mant_q;
	logic [T_W-1:0] res_q;

	logic [34:0] div_r2;
	logic        div_ge;
	logic [15:0] div_qn;
	logic [51:0] sq_t;
	logic        sq_ge;
	logic [50:0] sq_rtn;
	logic [61:0] ln_sq;
	logic [31:0] ln_t;
	logic [20:0] ln_lg;
	logic [53:0] ln_p;
	logic [5:0]  e_off;

	always_comb begin
		div_r2 = {r_q, 1'b0};
		div_ge = div_r2 >= {1'b0, d_q};
		div_qn = {q_q[14:0], div_ge};
		sq_t   = {1'b0, rt_q} + {1'b0, bit_q};
		sq_ge  = {1'b0, n_q} >= sq_t;
		sq_rtn = sq_ge ? ((rt_q >> 1) + bit_q) : (rt_q >> 1);
		ln_sq  = 62'(mant_q) * 62'(mant_q);
		ln_t   = ln_sq[61:30];
		e_off  = e_q - 6'd15;
		ln_lg  = {e_off[4:0], frac_q};
		ln_p   = 54'(ln_lg) * 54'(LN2_Q32) + 54'(33'h0_8000_0000);
	end

	assign done   = (state_q == X_DONE);
	assign result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= X_IDLE;
			cnt_q   <= '0;
			r_q <= '0; d_q <= '0; m_q <= '0; q_q <= '0; frac_q <= '0;
			n_q <= '0; rt_q <= '0; bit_q <= '0; e_q <= '0; mant_q <= '0;
			res_q <= '0;
		end else begin
			unique case (state_q)
				X_IDLE, X_DONE: begin
					state_q <= X_IDLE;
					if (start) begin
						case (kind)
							2'd0: begin
								r_q     <= {1'b0, v};
								d_q     <= {1'b0, v} + 34'd32768;
								q_q     <= '0;
								cnt_q   <= 5'd16;
								state_q <= X_DIV;
							end
							2'd1: begin
								m_q     <= {1'b0, v} + 34'd32768;
								e_q     <= 6'd33;
								state_q <= X_LNORM;
							end
							default: begin
								n_q     <= {1'b0, v, 17'b0};
								rt_q    <= '0;
								bit_q   <= 51'(1) << 50;
								cnt_q   <= 5'd26;
								state_q <= X_SQRT;
							end
						endcase
					end
				end
				X_DIV: begin
					q_q   <= div_qn;
					r_q   <= div_ge ? 34'(div_r2 - {1'b0, d_q}) : div_r2[33:0];
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd1) begin
						res_q   <= T_W'(div_qn);
						state_q <= X_DONE;
					end
				end
				X_SQRT: begin
					if (sq_ge)
						n_q <= n_q - sq_t[50:0];
					rt_q  <= sq_rtn;
					bit_q <= bit_q >> 2;
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd1) begin
						res_q   <= sq_rtn[T_W-1:0];
						state_q <= X_DONE;
					end
				end
				X_LNORM: begin
					// left-align the top bit, then truncate into a Q1.30 mantissa
					if (m_q[33]) begin
						mant_q  <= m_q[33:3];
						frac_q  <= '0;
						cnt_q   <= 5'd16;
						state_q <= X_LSQ;
					end else begin
						m_q <= {m_q[32:0], 1'b0};
						e_q <= e_q - 6'd1;
					end
				end
				X_LSQ: begin
					mant_q <= ln_t[31] ? ln_t[31:1] : ln_t[30:0];
					frac_q <= {frac_q[14:0], ln_t[31]};
					cnt_q  <= cnt_q - 5'd1;
					if (cnt_q == 5'd1)
						state_q <= X_LFIN;
				end
				X_LFIN: begin
					res_q   <= T_W'(ln_p[53:32]);
					state_q <= X_DONE;
				end
				default: state_q <= X_IDLE;
			endcase
		end
	end
endmodule

// ===== sv/cmg_front.sv =====
// Front end: accepts items, tracks the row element position, queues work for the back end.
// Depends on cmg_pkg.
module cmg_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  cmg_pkg::in_item_t  in_data,
	input  logic [6:0]         query_count,
	input  logic               blocked,
	input  logic               q_pop,
	output logic               q_valid,
	output cmg_pkg::work_t     q_entry
);
	import cmg_pkg::*;

	work_t            mem_q [WQ_DEPTH];
	logic [WQ_PW-1:0] wr_q, rd_q;
	logic [WQ_PW:0]   cnt_q;
	logic [QW-1:0]    pos_q;
	logic             accept, take;
	work_t            w;

	assign full    = (cnt_q == (WQ_PW+1)'(WQ_DEPTH)) || blocked;
	assign accept  = push && !full;
	assign q_valid = (cnt_q != '0);
	assign take    = q_pop && q_valid;
	assign q_entry = mem_q[rd_q];

	always_comb begin
		w.op   = op_t'(in_data.opcode);
		w.item = IW'(in_data.item_index);
		w.k    = in_data.kernel_value;
		w.last = in_data.last_element;
		w.pos  = pos_q;
		w.act  = 32'(pos_q) < 32'(query_count);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
			pos_q <= '0;
		end else begin
			if (accept) begin
				mem_q[wr_q] <= w;
				wr_q        <= wr_q + WQ_PW'(1);
				if (w.op == OP_CLEAR || w.op == OP_EVAL || w.last)
					pos_q <= '0;
				else
					pos_q <= pos_q + QW'(1);
			end
			if (take)
				rd_q <= rd_q + WQ_PW'(1);
			cnt_q <= cnt_q + (WQ_PW+1)'(accept) - (WQ_PW+1)'(take);
		end
	end
endmodule

// ===== sv/cmg_back.sv =====
// Back end: sequences transforms per element, keeps sums, selection map and totals.
// Depends on cmg_pkg, cmg_ram and cmg_xform.
module cmg_back (
	input  logic              clk,
	input  logic              arst_n,
	input  cmg_pkg::cfg_t     cfg,
	input  logic              q_valid,
	input  cmg_pkg::work_t    q_entry,
	output logic              q_pop,
	output logic              sweeping,
	input  logic              pop,
	output logic              empty,
	output cmg_pkg::out_item_t result
);
	import cmg_pkg::*;

	typedef enum logic [14:0] {
		B_SWEEP = 15'h0001, B_IDLE  = 15'h0002, B_RD    = 15'h0004,
		B_GOT   = 15'h0008, B_T1    = 15'h0010, B_T2    = 15'h0020,
		B_TR    = 15'h0040, B_WM    = 15'h0080, B_FIN   = 15'h0100,
		B_EM1   = 15'h0200, B_EM2   = 15'h0400, B_ERD   = 15'h0800,
		B_EGOT  = 15'h1000, B_EWAIT = 15'h2000, B_EOUT  = 15'h4000
	} bstate_t;

	bstate_t            state_q;
	work_t              cur_q;
	logic               sel_q;
	logic [SUM_W-1:0]   s_q, row_q;
	logic [T_W-1:0]     tpk_q, t_q;
	logic signed [GAIN_W-1:0] gain_q;
	logic [TOT_W-1:0]   smt_q;
	logic [41:0]        wprod_q;
	logic [47:0]        ppl_q;
	logic [23:0]        pph_q;
	logic [31:0]        acc_q;
	logic [QW-1:0]      pev_q;
	logic [IW-1:0]      sweep_q;
	logic [MAX_QUERIES-1:0] valid_q;
	logic               out_valid_q;
	out_item_t          out_q;

	logic               map_we, map_rdata;
	logic [IW-1:0]      map_waddr;
	logic               sums_we;
	logic [SUM_W-1:0]   sums_wdata, sums_rdata, s_now;
	logic [QW-1:0]      rd_idx;
	logic               x_start, x_done;
	logic [V_W-1:0]     x_v, sk, rk;
	logic [T_W-1:0]     x_res;
	logic [NW-1:0]      nq;
	logic [55:0]        wfull;
	logic [43:0]        wsh;
	logic [31:0]        acc_sum;
	logic signed [GAIN_W:0] rs;
	logic [TOT_W:0]     smt_sum;
	logic               fin_fire, eout_fire;

	assign sweeping = (state_q == B_SWEEP);
	assign empty    = !out_valid_q;
	assign result   = out_q;
	assign q_pop    = (state_q == B_IDLE) && q_valid;
	assign nq       = (32'(cfg.query_count) > MAX_QUERIES) ? NW'(MAX_QUERIES)
	                                                       : NW'(cfg.query_count);
	assign rd_idx   = (state_q == B_ERD || state_q == B_EGOT) ? pev_q : cur_q.pos;
	assign s_now    = valid_q[rd_idx] ? sums_rdata : '0;
	assign sk       = {1'b0, s_now} + V_W'(cur_q.k);
	assign rk       = {1'b0, row_q} + V_W'(cur_q.k);
	assign fin_fire  = (state_q == B_FIN) && !out_valid_q;
	assign eout_fire = (state_q == B_EOUT) && !out_valid_q;

	assign map_we    = sweeping || (fin_fire && cur_q.op == OP_ADD && !sel_q);
	assign map_waddr = sweeping ? sweep_q : cur_q.item;
	assign sums_we    = (state_q == B_GOT) && cur_q.act && cur_q.op == OP_ADD && !map_rdata;
	assign sums_wdata = sk[SUM_W] ? '1 : sk[SUM_W-1:0];

	always_comb begin
		wfull   = {pph_q, 32'b0} + 56'(ppl_q);
		wsh     = wfull[55:12];
		acc_sum = acc_q + 32'(x_res);
		rs      = $signed((GAIN_W+1)'(wprod_q[41:12])) + (GAIN_W+1)'(gain_q);
		smt_sum = {1'b0, smt_q} + (TOT_W+1)'(t_q);
	end

	always_comb begin
		x_start = 1'b0;
		x_v     = {1'b0, row_q};
		unique case (state_q)
			B_GOT: begin
				if (cur_q.act) begin
					x_start = 1'b1;
					x_v     = sk;
				end else if (cur_q.last) begin
					x_start = 1'b1;
				end
			end
			B_T1: begin
				x_start = x_done;
				x_v     = {1'b0, s_q};
			end
			B_T2: x_start = x_done && cur_q.last;
			B_EGOT: begin
				x_start = 1'b1;
				x_v     = {1'b0, s_now};
			end
			default: x_start = 1'b0;
		endcase
	end

	cmg_ram #(.W(1), .D(MAX_ITEMS)) u_map (
		.clk(clk), .we(map_we), .waddr(map_waddr), .wdata(!sweeping),
		.raddr(cur_q.item), .rdata(map_rdata)
	);

	cmg_ram #(.W(SUM_W), .D(MAX_QUERIES)) u_sums (
		.clk(clk), .we(sums_we), .waddr(cur_q.pos), .wdata(sums_wdata),
		.raddr(rd_idx), .rdata(sums_rdata)
	);

	cmg_xform u_xform (
		.clk(clk), .arst_n(arst_n), .start(x_start), .kind(cfg.transform_kind),
		.v(x_v), .done(x_done), .result(x_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_SWEEP;
			cur_q <= '0; sel_q <= 1'b0; s_q <= '0; row_q <= '0;
			tpk_q <= '0; t_q <= '0; gain_q <= '0; smt_q <= '0;
			wprod_q <= '0; ppl_q <= '0; pph_q <= '0; acc_q <= '0;
			pev_q <= '0; sweep_q <= '0; valid_q <= '0;
			out_valid_q <= 1'b0; out_q <= '0;
		end else begin
			if (pop && out_valid_q)
				out_valid_q <= 1'b0;
			unique case (state_q)
				B_SWEEP: begin
					sweep_q <= sweep_q + IW'(1);
					if (sweep_q == IW'(MAX_ITEMS - 1))
						state_q <= B_IDLE;
				end
				B_IDLE: begin
					if (q_valid) begin
						cur_q <= q_entry;
						case (q_entry.op)
							OP_CLEAR: begin
								valid_q <= '0;
								smt_q   <= '0;
								row_q   <= '0;
								gain_q  <= '0;
								sweep_q <= '0;
								state_q <= B_SWEEP;
							end
							OP_EVAL: begin
								row_q   <= '0;
								gain_q  <= '0;
								state_q <= B_EM1;
							end
							default: state_q <= B_RD;
						endcase
					end
				end
				B_RD: state_q <= B_GOT;
				B_GOT: begin
					sel_q <= map_rdata;
					s_q   <= s_now;
					if (cur_q.act) begin
						row_q <= rk[SUM_W] ? '1 : rk[SUM_W-1:0];
						if (sums_we)
							valid_q[cur_q.pos] <= 1'b1;
						state_q <= B_T1;
					end else if (cur_q.last)
						state_q <= B_TR;
					else
						state_q <= B_IDLE;
				end
				B_T1: begin
					if (x_done) begin
						tpk_q   <= x_res;
						state_q <= B_T2;
					end
				end
				B_T2: begin
					if (x_done) begin
						gain_q  <= gain_q + GAIN_W'(tpk_q) - GAIN_W'(x_res);
						state_q <= cur_q.last ? B_TR : B_IDLE;
					end
				end
				B_TR: begin
					if (x_done) begin
						t_q     <= x_res;
						state_q <= B_WM;
					end
				end
				B_WM: begin
					wprod_q <= 42'(cfg.diversity_weight) * 42'(t_q);
					state_q <= B_FIN;
				end
				B_FIN: begin
					if (fin_fire) begin
						if (sel_q && cfg.check_membership)
							out_q.result_value <= '0;
						else if (rs > (GAIN_W+1)'(32'sh7FFF_FFFF))
							out_q.result_value <= 32'sh7FFF_FFFF;
						else if (rs < -(GAIN_W+1)'(33'sh0_8000_0000))
							out_q.result_value <= 32'sh8000_0000;
						else
							out_q.result_value <= rs[31:0];
						out_q.already_selected <= sel_q;
						out_valid_q <= 1'b1;
						if (cur_q.op == OP_ADD && !sel_q)
							smt_q <= smt_sum[TOT_W] ? '1 : smt_sum[TOT_W-1:0];
						row_q   <= '0;
						gain_q  <= '0;
						state_q <= B_IDLE;
					end
				end
				B_EM1: begin
					// eta times the 40-bit total, as two partial products
					ppl_q   <= 48'(cfg.diversity_weight) * 48'(smt_q[31:0]);
					pph_q   <= 24'(cfg.diversity_weight) * 24'(smt_q[39:32]);
					state_q <= B_EM2;
				end
				B_EM2: begin
					acc_q   <= (|wsh[43:31]) ? 32'h8000_0000 : wsh[31:0];
					pev_q   <= '0;
					state_q <= (nq == '0) ? B_EOUT : B_ERD;
				end
				B_ERD:  state_q <= B_EGOT;
				B_EGOT: state_q <= B_EWAIT;
				B_EWAIT: begin
					if (x_done) begin
						// anything at or above 2^31 saturates, so clip there
						acc_q <= acc_sum[31] ? 32'h8000_0000 : acc_sum;
						pev_q <= pev_q + QW'(1);
						state_q <= ((NW'(pev_q) + NW'(1)) == nq) ? B_EOUT : B_ERD;
					end
				end
				B_EOUT: begin
					if (eout_fire) begin
						out_q.result_value     <= acc_q[31] ? 32'sh7FFF_FFFF : acc_q;
						out_q.already_selected <= 1'b0;
						out_valid_q <= 1'b1;
						state_q     <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end
endmodule

// ===== sv/concave_over_modular_gain.sv =====
// Concave-over-modular marginal gain engine. Each active row element takes two
// transforms on the shared unit (divide, root or log). A row's last element adds
// one more transform; evaluate takes one transform per query in use. One item is
// worked on at a time behind a 2-deep queue.
// After reset, and after each clear, the selection map is swept with full high.
module concave_over_modular_gain (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  cmg_pkg::in_item_t   in_data,
	output logic                empty,
	input  logic                pop,
	output cmg_pkg::out_item_t  result,
	input  logic                cfg_write,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data
);
	import cmg_pkg::*;

	cfg_t   cfg_q;
	logic   q_valid, q_pop, sweeping;
	work_t  q_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.transform_kind   <= 2'd2;
			cfg_q.diversity_weight <= 16'd4096;
			cfg_q.query_count      <= 7'd64;
			cfg_q.check_membership <= 1'b1;
		end else if (cfg_write) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_KIND:   cfg_q.transform_kind   <= cfg_data[1:0];
				CFG_ETA:    cfg_q.diversity_weight <= cfg_data;
				CFG_QCOUNT: cfg_q.query_count      <= cfg_data[6:0];
				CFG_CHECK:  cfg_q.check_membership <= cfg_data[0];
				default:    cfg_q.check_membership <= cfg_q.check_membership;
			endcase
		end
	end

	cmg_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_data(in_data),
		.query_count(cfg_q.query_count), .blocked(sweeping),
		.q_pop(q_pop), .q_valid(q_valid), .q_entry(q_entry)
	);

	cmg_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .q_valid(q_valid), .q_entry(q_entry),
		.q_pop(q_pop), .sweeping(sweeping), .pop(pop), .empty(empty), .result(result)
	);
endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for concave_over_modular_gain.
// Drives directed and random beats, predicts every result and checks it against the RTL.
// Depends on cmg_pkg and the concave_over_modular_gain RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import cmg_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int DRAIN_WAIT  = 5000;
	localparam longint unsigned LN2_K = 64'd2977044472;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	in_item_t in_data = '0;
	logic empty;
	logic pop = 1'b0;
	out_item_t result;
	logic cfg_write = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	concave_over_modular_gain uut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_data(in_data),
		.empty(empty), .pop(pop), .result(result),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor copy of configuration and state
	logic [1:0] p_kind;
	logic [15:0] p_eta;
	logic [6:0] p_qcount;
	logic p_check;
	longint unsigned p_qsum[MAX_QUERIES];
	bit p_sel[MAX_ITEMS];
	longint unsigned p_row;
	longint p_gain;
	longint unsigned p_total;
	int unsigned p_pos;

	out_item_t expected_q[$];
	int fails = 0;
	int cycles = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	bit hold_go = 0;
	bit hold_seen = 0;
	int hold_left = 0;

	function automatic longint unsigned root_q(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 50;
		for (int i = 0; i < 26; i++) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint unsigned log_q(longint unsigned v);
		longint unsigned u, m, frac, lg;
		int e;
		u = v + 32768;
		e = 0;
		frac = 0;
		for (int i = 0; i < 63; i++)
			if (u[i]) e = i;
		if (e <= 30) m = u << (30 - e);
		else m = u >> (e - 30);
		for (int i = 1; i <= 16; i++) begin
			m = (m * m) >> 30;
			if (m >= (64'd1 << 31)) begin
				m = m >> 1;
				frac = frac | (64'd1 << (16 - i));
			end
		end
		lg = (longint'(e - 15) << 16) | frac;
		return (lg * LN2_K + (64'd1 << 31)) >> 32;
	endfunction

	function automatic longint unsigned concave_q(longint unsigned v);
		if (p_kind == 2'd0) return (v << 16) / (v + 32768);
		if (p_kind == 2'd1) return log_q(v);
		return root_q(v << 17);
	endfunction

	function automatic longint unsigned eta_scale(longint unsigned t);
		return (longint'(p_eta) * t) >> 12;
	endfunction

	function automatic logic [31:0] clip32(longint x);
		if (x > 64'sd2147483647) x = 64'sd2147483647;
		if (x < -64'sd2147483648) x = -64'sd2147483648;
		return x[31:0];
	endfunction

	function automatic void clear_row();
		p_row = 0;
		p_gain = 0;
		p_pos = 0;
	endfunction

	function automatic void reset_model();
		p_kind = 2'd2;
		p_eta = 16'd4096;
		p_qcount = 7'd64;
		p_check = 1'b1;
		foreach (p_qsum[i]) p_qsum[i] = 0;
		foreach (p_sel[i]) p_sel[i] = 0;
		p_total = 0;
		clear_row();
	endfunction

	function automatic bit predict_gain(input in_item_t it, output out_item_t o);
		int unsigned n, item;
		longint unsigned s, k, t, tot;
		longint res;
		bit was;
		item = it.item_index;
		k = it.kernel_value;
		was = p_sel[item];
		o = '0;
		n = (p_qcount > MAX_QUERIES) ? MAX_QUERIES : p_qcount;
		if (it.opcode == OP_CLEAR) begin
			foreach (p_qsum[i]) p_qsum[i] = 0;
			foreach (p_sel[i]) p_sel[i] = 0;
			p_total = 0;
			clear_row();
			return 0;
		end
		if (it.opcode == OP_EVAL) begin
			tot = eta_scale(p_total);
			for (int q = 0; q < n; q++) tot += concave_q(p_qsum[q]);
			clear_row();
			o.result_value = (tot > 64'd2147483647) ? 32'h7fffffff : tot[31:0];
			return 1;
		end
		if (p_pos < n) begin
			s = p_qsum[p_pos];
			p_row += k;
			if (p_row > 64'hffffffff) p_row = 64'hffffffff;
			p_gain += longint'(concave_q(s + k)) - longint'(concave_q(s));
			if (it.opcode == OP_ADD && !was) begin
				s += k;
				p_qsum[p_pos] = (s > 64'hffffffff) ? 64'hffffffff : s;
			end
		end
		p_pos = (p_pos + 1) % MAX_QUERIES;
		if (!it.last_element) return 0;
		t = concave_q(p_row);
		res = (was && p_check) ? 0 : longint'(eta_scale(t)) + p_gain;
		if (it.opcode == OP_ADD && !was) begin
			p_sel[item] = 1;
			p_total += t;
			if (p_total > 64'hffffffffff) p_total = 64'hffffffffff;
		end
		clear_row();
		o.result_value = clip32(res);
		o.already_selected = was;
		return 1;
	endfunction

	// one beat onto the input queue, with random idle cycles before it
	task automatic send_beat(input in_item_t it, input bit typed, input out_item_t typed_out);
		out_item_t o;
		forever begin
			@(negedge clk);
			if ($urandom_range(99) < idle_pct) push = 1'b0;
			else break;
		end
		push = 1'b1;
		in_data = it;
		do @(posedge clk); while (full);
		if (predict_gain(it, o)) begin
			if (typed) o = typed_out;
			expected_q = {expected_q, o};
		end
	endtask

	task automatic send(input in_item_t it);
		send_beat(it, 1'b0, '0);
	endtask

	task automatic drain();
		@(negedge clk);
		push = 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
		@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_write = 1'b0;
		case (idx)
			CFG_KIND:   p_kind = val[1:0];
			CFG_ETA:    p_eta = val;
			CFG_QCOUNT: p_qcount = val[6:0];
			default:    p_check = val[0];
		endcase
	endtask

	// receiver side: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_seen != hold_go) begin
			hold_seen = hold_go;
			hold_left = 600;
		end
		if (hold_left > 0) begin
			hold_left--;
			pop = 1'b0;
		end else begin
			pop = ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		out_item_t e;
		if (arst_n && pop && !empty) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result beat, expected none, actual %h/%b", $time,
					result.result_value, result.already_selected);
				fails++;
			end else begin
				e = expected_q.pop_front();
				if (result.result_value !== e.result_value) begin
					$display("%0t: result_value expected %h actual %h", $time,
						e.result_value, result.result_value);
					fails++;
				end
				if (result.already_selected !== e.already_selected) begin
					$display("%0t: already_selected expected %b actual %b", $time,
						e.already_selected, result.already_selected);
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("concave_over_modular_gain verification failed");
			$finish;
		end
	end

	typedef struct {
		in_item_t it;
		bit typed;
		int val;
		bit sel;
	} dir_row_t;

	dir_row_t dir_tab[17] = '{
		'{'{OP_EVAL,  12'd0,    16'h0000, 1'b1}, 1, 0, 0},
		'{'{OP_GAIN,  12'd0,    16'h0000, 1'b1}, 1, 0, 0},
		'{'{OP_GAIN,  12'd0,    16'hffff, 1'b1}, 0, 0, 0},
		'{'{OP_ADD,   12'd4095, 16'hffff, 1'b1}, 0, 0, 0},
		'{'{OP_GAIN,  12'd4095, 16'h1234, 1'b1}, 1, 0, 1},
		'{'{OP_ADD,   12'd4095, 16'h0007, 1'b1}, 1, 0, 1},
		'{'{OP_ADD,   12'd1,    16'h8000, 1'b0}, 0, 0, 0},
		'{'{OP_EVAL,  12'd0,    16'hffff, 1'b0}, 0, 0, 0},
		'{'{OP_GAIN,  12'd2,    16'h0100, 1'b0}, 0, 0, 0},
		'{'{OP_CLEAR, 12'd3,    16'hffff, 1'b1}, 0, 0, 0},
		'{'{OP_EVAL,  12'd0,    16'h0000, 1'b1}, 1, 0, 0},
		'{'{OP_ADD,   12'd5,    16'hffff, 1'b0}, 0, 0, 0},
		'{'{OP_ADD,   12'd5,    16'h0001, 1'b1}, 0, 0, 0},
		'{'{OP_GAIN,  12'd2730, 16'haaaa, 1'b0}, 0, 0, 0},
		'{'{OP_GAIN,  12'd1365, 16'h5555, 1'b1}, 0, 0, 0},
		'{'{OP_EVAL,  12'd4095, 16'h0000, 1'b1}, 0, 0, 0},
		'{'{OP_CLEAR, 12'd0,    16'h0000, 1'b0}, 0, 0, 0}
	};

	// kind, eta, query count, check, sender idle %, receiver stall %
	int phase_tab[8][6] = '{
		'{2, 4096,  4,   1, 0,  0},
		'{0, 0,     1,   0, 49, 0},
		'{1, 65535, 8,   1, 0,  49},
		'{3, 12345, 64,  0, 19, 19},
		'{1, 300,   0,   1, 49, 0},
		'{0, 65535, 127, 1, 0,  49},
		'{2, 1,     3,   0, 19, 19},
		'{1, 8191,  5,   1, 0,  0}
	};

	logic [11:0] item_pool[8] = '{12'd0, 12'd4095, 12'd1, 12'd7, 12'd100, 12'd2048,
		12'd3000, 12'd63};

	initial begin
		in_item_t it;
		out_item_t o;
		int n, len, count;
		logic [11:0] item;
		reset_model();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_tab[i]) begin
			o.result_value = dir_tab[i].val;
			o.already_selected = dir_tab[i].sel;
			send_beat(dir_tab[i].it, dir_tab[i].typed, o);
		end

		for (int ph = 0; ph < 8; ph++) begin
			drain();
			write_reg(CFG_KIND, 16'(phase_tab[ph][0]));
			write_reg(CFG_ETA, 16'(phase_tab[ph][1]));
			write_reg(CFG_QCOUNT, 16'(phase_tab[ph][2]));
			write_reg(CFG_CHECK, 16'(phase_tab[ph][3]));
			idle_pct = phase_tab[ph][4];
			stall_pct = phase_tab[ph][5];
			if (ph == 6) hold_go = !hold_go;
			n = (phase_tab[ph][2] > MAX_QUERIES) ? MAX_QUERIES : phase_tab[ph][2];
			if (n < 1) n = 1;
			count = 0;
			while (count < 92) begin
				if (ph == 7 && count > 40 && count < 48) begin
					drain();
					count = 48;
				end
				case ($urandom_range(99)) inside
					[0:2]: begin
						it = '0;
						it.opcode = OP_CLEAR;
						it.item_index = 12'($urandom);
						it.kernel_value = 16'($urandom);
						it.last_element = 1'($urandom);
						send(it);
						count++;
					end
					[3:10]: begin
						it = '0;
						it.opcode = OP_EVAL;
						it.item_index = 12'($urandom);
						it.kernel_value = 16'($urandom);
						it.last_element = 1'($urandom);
						send(it);
						count++;
					end
					default: begin
						case ($urandom_range(9))
							0: len = $urandom_range(n, 1);
							1: len = n + $urandom_range(3, 1);
							default: len = n;
						endcase
						item = ($urandom_range(2) == 0) ? 12'($urandom) :
							item_pool[$urandom_range(7)];
						it.opcode = ($urandom_range(1) == 0) ? OP_GAIN : OP_ADD;
						for (int e = 0; e < len; e++) begin
							it.item_index = ($urandom_range(19) == 0) ? 12'($urandom) : item;
							case ($urandom_range(7))
								0: it.kernel_value = 16'h0000;
								1: it.kernel_value = 16'hffff;
								default: it.kernel_value = 16'($urandom);
							endcase
							it.last_element = (e == len - 1);
							send(it);
						end
						count += len;
					end
				endcase
			end
		end

		drain();
		if (fails == 0) begin
			$display("concave_over_modular_gain verification clean");
		end else begin
			$display("concave_over_modular_gain verification failed");
		end
		$finish;
	end

endmodule
